### design/gsc_pkg.sv
`timescale 1ns / 1ps
// gsc_pkg: shared types, codes and constants of the grid step CV sequencer.
// No dependencies.
package gsc_pkg;

   localparam int LEVEL_W   = 16;
   localparam int VALUE_W   = 3;
   localparam int PAD_W     = 6;
   localparam int ACTION_W  = 2;
   localparam int CHANNEL_W = 4;
   localparam int PLAY_W    = 3;
   localparam int DIV_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef logic [LEVEL_W-1:0]   level_type;
   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [ACTION_W-1:0]  action_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam action_type ACT_TICK  = 2'd0;
   localparam action_type ACT_STRIP = 2'd1;
   localparam action_type ACT_PAD   = 2'd2;
   localparam action_type ACT_PAGE  = 2'd3;

   localparam csr_idx_type CSR_CLOCK_DIVIDE  = 2'd0;
   localparam csr_idx_type CSR_SLEW_STEP     = 2'd1;
   localparam csr_idx_type CSR_TRIGGER_TICKS = 2'd2;

   localparam logic [DIV_W-1:0]   CLOCK_DIVIDE_RST  = 7'd1;
   localparam logic [LEVEL_W-1:0] SLEW_STEP_RST     = 16'd0;
   localparam logic [15:0]        TRIGGER_TICKS_RST = 16'd240;

   localparam value_type TOP_ROW_INV = 3'd7;

   // round(v * full / 7)
   function automatic level_type gsc_target(input value_type v);
      level_type t;
      unique case (v)
         3'd0: t = 16'd0;
         3'd1: t = 16'd9362;
         3'd2: t = 16'd18724;
         3'd3: t = 16'd28086;
         3'd4: t = 16'd37449;
         3'd5: t = 16'd46811;
         3'd6: t = 16'd56173;
         3'd7: t = 16'd65535;
         default: t = 16'd0;
      endcase
      return t;
   endfunction

endpackage

### design/gsc_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and configuration writes.
// Depends on gsc_pkg.
interface gsc_req_if;
   import gsc_pkg::*;
   logic               valid;
   logic               ready;
   logic [ACTION_W-1:0] action;
   logic               clock_tick;
   logic               reset_tick;
   logic [PAD_W-1:0]   pad_index;
   logic               pressed;
   modport source (output valid, action, clock_tick, reset_tick, pad_index, pressed,
                   input ready);
   modport sink   (input valid, action, clock_tick, reset_tick, pad_index, pressed,
                   output ready);
endinterface

interface gsc_rsp_if;
   import gsc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHANNEL_W-1:0] channel;
   logic [LEVEL_W-1:0]   level;
   logic                 trigger_high;
   logic [PLAY_W-1:0]    playhead;
   logic                 last;
   modport source (output valid, channel, level, trigger_high, playhead, last,
                   input ready);
   modport sink   (input valid, channel, level, trigger_high, playhead, last,
                   output ready);
endinterface

interface gsc_csr_if;
   import gsc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/gsc_slew_unit.sv
`timescale 1ns / 1ps
// gsc_slew_unit: moves one level toward its target by at most one slew step (a zero step jumps to the target).
// Depends on gsc_pkg; shared by all channels.
module gsc_slew_unit (
   input  gsc_pkg::level_type cur,
   input  gsc_pkg::level_type target,
   input  gsc_pkg::level_type slew_step,
   output gsc_pkg::level_type next
);
   import gsc_pkg::*;

   logic      up;
   level_type diff;

   assign up   = (target >= cur);
   assign diff = up ? (target - cur) : (cur - target);

   always_comb begin
      if ((slew_step == '0) || (diff <= slew_step)) begin
         next = target;
      end else if (up) begin
         next = cur + slew_step;
      end else begin
         next = cur - slew_step;
      end
   end

endmodule

### design/gsc_strip_ctrl.sv
`timescale 1ns / 1ps
// gsc_strip_ctrl: bottom-row strip logic, playhead jumps and loop range setting.
// Depends on gsc_pkg.
module gsc_strip_ctrl #(
   parameter int STEPS = 8,
   parameter int CW    = (STEPS > 1) ? $clog2(STEPS) : 1
) (
   input  logic [STEPS-1:0] held,
   input  logic             pair_done,
   input  logic [CW-1:0]    range_first,
   input  logic [CW-1:0]    range_final,
   input  logic [CW-1:0]    play,
   input  logic [CW-1:0]    col,
   input  logic             pressed,
   output logic [STEPS-1:0] held_in,
   output logic             pair_done_in,
   output logic [CW-1:0]    range_first_in,
   output logic [CW-1:0]    range_final_in,
   output logic [CW-1:0]    play_in
);
   import gsc_pkg::*;

   logic          found;
   logic [CW-1:0] other;
   logic [CW-1:0] lo;
   logic [CW-1:0] hi;

   // lowest held pad other than this one
   always_comb begin
      found = 1'b0;
      other = '0;
      for (int c = STEPS - 1; c >= 0; c--) begin
         if (held[c] && (CW'(c) != col)) begin
            found = 1'b1;
            other = CW'(c);
         end
      end
   end

   assign lo = (other < col) ? other : col;
   assign hi = (other < col) ? col : other;

   always_comb begin
      held_in        = held;
      pair_done_in   = pair_done;
      range_first_in = range_first;
      range_final_in = range_final;
      play_in        = play;
      if (pressed) begin
         held_in[col] = 1'b1;
         if (found) begin
            range_first_in = lo;
            range_final_in = hi;
            pair_done_in   = 1'b1;
            if ((play < lo) || (play > hi)) begin
               play_in = lo;
            end
         end
      end else begin
         held_in[col] = 1'b0;
         if (held_in == '0) begin
            if (!pair_done && (col >= range_first) && (col <= range_final)) begin
               play_in = col;
            end
            pair_done_in = 1'b0;
         end
      end
   end

endmodule

### design/grid_step_cv_sequencer_core.sv
`timescale 1ns / 1ps
// grid_step_cv_sequencer_core: top level, sequencer, state and result register.
// Depends on gsc_pkg, gsc_ifs, gsc_slew_unit, gsc_strip_ctrl.
//
//  channel   dir   carries
//  req_ch    in    action, clock_tick, reset_tick, pad_index, pressed
//  rsp_ch    out   channel, level, trigger_high, playhead, last
//  csr_ch    in    index, data (always ready)
//
// A sample tick is accepted, then gives one level per cycle, main level first, through
// the single shared slew unit while rsp_ch does not stall. Strip, pad and page
// items give no result.
// Reset is synchronous and clears all state but the data fields of the result register.
// A stalled rsp_ch holds the sequencer; req_ch is ready only between ticks.
module grid_step_cv_sequencer_core #(
   parameter int STEPS = 8
) (
   input logic      clock,
   input logic      reset,
   gsc_req_if.sink  req_ch,
   gsc_rsp_if.source rsp_ch,
   gsc_csr_if.sink  csr_ch
);
   import gsc_pkg::*;

   localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int NW = $clog2(STEPS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // configuration
   logic [DIV_W-1:0] clock_divide_ff;
   level_type        slew_step_ff;
   logic [15:0]      trigger_ticks_ff;

   // sequencer state
   logic             state_ff, state_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic             trig_ff, trig_in;

   value_type        step_values_ff [STEPS];
   level_type        column_levels_ff [STEPS];
   level_type        main_level_ff;
   logic [CW-1:0]    play_ff, play_in;
   logic [CW-1:0]    first_ff, first_in;
   logic [CW-1:0]    final_ff, final_in;
   logic             strip_down_ff, strip_down_in;
   logic [STEPS-1:0] held_ff, held_in;
   logic             pair_ff, pair_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [15:0]      pulse_ff, pulse_in;

   // result register
   logic                 rsp_valid_ff;
   logic [CHANNEL_W-1:0] rsp_channel_ff;
   level_type            rsp_level_ff;
   logic                 rsp_trig_ff;
   logic [PLAY_W-1:0]    rsp_play_ff;
   logic                 rsp_last_ff;

   logic acc, csr_acc, step_go, cnt_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign acc          = req_ch.valid && req_ch.ready;
   assign csr_acc      = csr_ch.valid;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.channel      = rsp_channel_ff;
   assign rsp_ch.level        = rsp_level_ff;
   assign rsp_ch.trigger_high = rsp_trig_ff;
   assign rsp_ch.playhead     = rsp_play_ff;
   assign rsp_ch.last         = rsp_last_ff;

   // pad decode
   logic [2:0]    pad_row, pad_col;
   logic          pad_ok;
   logic [CW-1:0] col_idx;

   assign pad_row = req_ch.pad_index[5:3];
   assign pad_col = req_ch.pad_index[2:0];
   assign pad_ok  = (int'(pad_col) < STEPS);
   assign col_idx = CW'(pad_col);

   logic [STEPS-1:0] sp_held;
   logic             sp_pair;
   logic [CW-1:0]    sp_first, sp_final, sp_play;

   gsc_strip_ctrl #(
      .STEPS (STEPS),
      .CW    (CW)
   ) u_strip (
      .held           (held_ff),
      .pair_done      (pair_ff),
      .range_first    (first_ff),
      .range_final    (final_ff),
      .play           (play_ff),
      .col            (col_idx),
      .pressed        (req_ch.pressed),
      .held_in        (sp_held),
      .pair_done_in   (sp_pair),
      .range_first_in (sp_first),
      .range_final_in (sp_final),
      .play_in        (sp_play)
   );

   // tick front end: reset, divider, advance, pulse
   logic [CW-1:0]    tk_play;
   logic [DIV_W-1:0] tk_div, tk_div_inc;
   logic [15:0]      tk_pulse;
   logic             tk_fire;

   always_comb begin
      tk_play    = req_ch.reset_tick ? first_ff : play_ff;
      tk_div     = req_ch.reset_tick ? '0 : div_ff;
      tk_div_inc = tk_div + DIV_W'(1);
      tk_fire    = req_ch.clock_tick && (tk_div_inc >= clock_divide_ff);
      tk_pulse   = pulse_ff;
      if (req_ch.clock_tick) begin
         tk_div = tk_fire ? '0 : tk_div_inc;
      end
      if (tk_fire) begin
         if ((tk_play < first_ff) || (tk_play >= final_ff)) begin
            tk_play = first_ff;
         end else begin
            tk_play = tk_play + CW'(1);
         end
         tk_pulse = trigger_ticks_ff;
      end
   end

   // shared slew unit
   logic [NW-1:0] cnt_m1;
   logic [CW-1:0] col_sel, rd_idx;
   level_type     su_cur, su_target, su_next;

   assign cnt_m1    = cnt_ff - NW'(1);
   assign col_sel   = cnt_m1[CW-1:0];
   assign rd_idx    = (cnt_ff == '0) ? play_ff : col_sel;
   assign su_cur    = (cnt_ff == '0) ? main_level_ff : column_levels_ff[col_sel];
   assign su_target = gsc_target(step_values_ff[rd_idx]);
   assign cnt_last  = (cnt_ff == NW'(STEPS));
   assign step_go   = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ch.ready);

   gsc_slew_unit u_slew (
      .cur       (su_cur),
      .target    (su_target),
      .slew_step (slew_step_ff),
      .next      (su_next)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      trig_in       = trig_ff;
      play_in       = play_ff;
      first_in      = first_ff;
      final_in      = final_ff;
      strip_down_in = strip_down_ff;
      held_in       = held_ff;
      pair_in       = pair_ff;
      div_in        = div_ff;
      pulse_in      = pulse_ff;
      if (acc) begin
         unique case (req_ch.action)
            ACT_TICK: begin
               play_in  = tk_play;
               div_in   = tk_div;
               trig_in  = (tk_pulse != '0);
               pulse_in = (tk_pulse != '0) ? (tk_pulse - 16'd1) : '0;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
            ACT_STRIP: begin
               if (req_ch.pressed) begin
                  strip_down_in = 1'b1;
               end else begin
                  strip_down_in = 1'b0;
                  held_in       = '0;
                  pair_in       = 1'b0;
               end
            end
            ACT_PAD: begin
               if (pad_ok && strip_down_ff && (pad_row == TOP_ROW_INV)) begin
                  held_in  = sp_held;
                  pair_in  = sp_pair;
                  first_in = sp_first;
                  final_in = sp_final;
                  play_in  = sp_play;
               end
            end
            ACT_PAGE: begin
               strip_down_in = 1'b0;
               held_in       = '0;
               pair_in       = 1'b0;
            end
            default: ;
         endcase
      end else if (step_go) begin
         cnt_in = cnt_ff + NW'(1);
         if (cnt_last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cnt_ff           <= '0;
         trig_ff          <= 1'b0;
         play_ff          <= '0;
         first_ff         <= '0;
         final_ff         <= CW'(STEPS - 1);
         strip_down_ff    <= 1'b0;
         held_ff          <= '0;
         pair_ff          <= 1'b0;
         div_ff           <= '0;
         pulse_ff         <= '0;
         main_level_ff    <= '0;
         clock_divide_ff  <= CLOCK_DIVIDE_RST;
         slew_step_ff     <= SLEW_STEP_RST;
         trigger_ticks_ff <= TRIGGER_TICKS_RST;
         rsp_valid_ff     <= 1'b0;
         for (int i = 0; i < STEPS; i++) begin
            step_values_ff[i]   <= '0;
            column_levels_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         trig_ff       <= trig_in;
         play_ff       <= play_in;
         first_ff      <= first_in;
         final_ff      <= final_in;
         strip_down_ff <= strip_down_in;
         held_ff       <= held_in;
         pair_ff       <= pair_in;
         div_ff        <= div_in;
         pulse_ff      <= pulse_in;
         if (csr_acc) begin
            unique case (csr_ch.index)
               CSR_CLOCK_DIVIDE:  clock_divide_ff  <= csr_ch.data[DIV_W-1:0];
               CSR_SLEW_STEP:     slew_step_ff     <= csr_ch.data[LEVEL_W-1:0];
               CSR_TRIGGER_TICKS: trigger_ticks_ff <= csr_ch.data;
               default: ;
            endcase
         end
         if (acc && (req_ch.action == ACT_PAD) && pad_ok && req_ch.pressed &&
             !(strip_down_ff && (pad_row == TOP_ROW_INV))) begin
            step_values_ff[col_idx] <= ~pad_row;
         end
         if (step_go) begin
            if (cnt_ff == '0) begin
               main_level_ff <= su_next;
            end else begin
               column_levels_ff[col_sel] <= su_next;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         rsp_channel_ff <= CHANNEL_W'(cnt_ff);
         rsp_level_ff   <= su_next;
         rsp_trig_ff    <= trig_ff;
         rsp_play_ff    <= PLAY_W'(play_ff);
         rsp_last_ff    <= cnt_last;
      end
   end

   // a waiting last item may overlap the next tick only before its first level is computed
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ((state_ff == ST_IDLE) || (cnt_ff == '0)))
      else $error("last result shown while sequencer mid-tick");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      first_ff <= final_ff)
      else $error("loop range inverted");

   a_tick_runs: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_ch.action == ACT_TICK)) |=> ((state_ff == ST_RUN) && (cnt_ff == '0)))
      else $error("accepted tick did not start the sequencer");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (cnt_ff <= NW'(STEPS)))
      else $error("channel counter overran");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for grid_step_cv_sequencer_core.
// Depends on gsc_pkg and gsc_ifs. A directed table, then random phases with
// varied settings, are checked against an in-bench model of the sequencer.
module tb_top;
   import gsc_pkg::*;

   localparam int STEPS          = 8;
   localparam int STRIP_ROW      = 7;
   localparam int IDLE_PCT       = 32;
   localparam int SETTLE_CYCLES  = 16;
   localparam int END_CYCLES     = 40;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int unsigned LEVEL_FULL = (1 << LEVEL_W) - 1;
   localparam csr_idx_type CSR_SPARE = 2'd3;

   typedef struct packed {
      action_type       action;
      logic             clock_tick;
      logic             reset_tick;
      logic [PAD_W-1:0] pad_index;
      logic             pressed;
   } seq_item_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      level_type            level;
      logic                 trigger_high;
      logic [PLAY_W-1:0]    playhead;
      logic                 last;
   } level_item_type;

   // hand-typed expectation for the main level of a directed tick
   typedef struct packed {
      logic              on;
      level_type         level;
      logic              trigger_high;
      logic [PLAY_W-1:0] playhead;
   } main_pin_type;

   typedef struct {
      seq_item_type it;
      main_pin_type pin;
   } dir_row_type;

   typedef struct {
      logic [CSR_DAT_W-1:0] divide;
      logic [CSR_DAT_W-1:0] slew;
      logic [CSR_DAT_W-1:0] trig;
      int                   items;
      int                   tick_pct;
      bit                   full_speed;
      bit                   pressure;
      bit                   spare_write;
   } phase_type;

   logic clock;
   logic reset;

   gsc_req_if req_ch();
   gsc_rsp_if rsp_ch();
   gsc_csr_if csr_ch();

   grid_step_cv_sequencer_core #(.STEPS(STEPS)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // sequencer model state
   value_type         step_val [STEPS];
   level_type         col_lvl [STEPS];
   level_type         main_lvl;
   logic [2:0]        play_col;
   logic [2:0]        loop_first;
   logic [2:0]        loop_last;
   logic              strip_held;
   logic              pair_set;
   logic [STEPS-1:0]  held_mask;
   logic [DIV_W-1:0]  div_cnt;
   logic [15:0]       pulse_cnt;
   logic [DIV_W-1:0]  cfg_divide;
   level_type         cfg_slew;
   logic [15:0]       cfg_trig;

   level_item_type expected_levels[$];
   int             pending;
   int             quiet_cycles;
   int             mismatches;
   int             results_checked;
   int             ticks_accepted;
   int             others_accepted;
   int             items_sent;
   main_pin_type   cur_pin;
   bit             full_speed;
   bit             hold_rsp;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic level_type aim_level(input value_type v);
      int unsigned scaled;
      scaled = (32'(v) * LEVEL_FULL + 3) / 7;
      return level_type'(scaled);
   endfunction

   function automatic level_type slew_level(input level_type cur, input level_type aim);
      level_type gap;
      if (cfg_slew == 0) return aim;
      if (aim >= cur) begin
         gap = aim - cur;
         return (gap <= cfg_slew) ? aim : level_type'(cur + cfg_slew);
      end
      gap = cur - aim;
      return (gap <= cfg_slew) ? aim : level_type'(cur - cfg_slew);
   endfunction

   function automatic void drop_strip();
      strip_held = 1'b0;
      held_mask  = '0;
      pair_set   = 1'b0;
   endfunction

   function automatic void clear_sequencer();
      int i;
      cfg_divide = CLOCK_DIVIDE_RST;
      cfg_slew   = SLEW_STEP_RST;
      cfg_trig   = TRIGGER_TICKS_RST;
      for (i = 0; i < STEPS; i++) begin
         step_val[i] = '0;
         col_lvl[i]  = '0;
      end
      play_col   = '0;
      loop_first = '0;
      loop_last  = 3'(STEPS - 1);
      drop_strip();
      main_lvl   = '0;
      div_cnt    = '0;
      pulse_cnt  = '0;
   endfunction

   function automatic void write_setting(input csr_idx_type idx,
                                         input logic [CSR_DAT_W-1:0] data);
      case (idx)
         CSR_CLOCK_DIVIDE:  cfg_divide = data[DIV_W-1:0];
         CSR_SLEW_STEP:     cfg_slew   = data;
         CSR_TRIGGER_TICKS: cfg_trig   = data;
         default: ;
      endcase
   endfunction

   // bottom-row pad while the strip button is held
   function automatic void strip_pad_event(input logic [2:0] col, input logic down);
      logic       found;
      logic [2:0] other;
      int         c;
      found = 1'b0;
      other = '0;
      if (down) begin
         for (c = 0; c < STEPS; c++) begin
            if (!found && 3'(c) != col && held_mask[c]) begin
               found = 1'b1;
               other = 3'(c);
            end
         end
         held_mask[col] = 1'b1;
         if (found) begin
            loop_first = (other < col) ? other : col;
            loop_last  = (other < col) ? col : other;
            if (play_col < loop_first || play_col > loop_last) play_col = loop_first;
            pair_set = 1'b1;
         end
      end else begin
         held_mask[col] = 1'b0;
         if (held_mask == '0) begin
            if (!pair_set && col >= loop_first && col <= loop_last) play_col = col;
            pair_set = 1'b0;
         end
      end
   endfunction

   function automatic void run_item(input seq_item_type it, input main_pin_type pin);
      level_item_type r;
      logic           trig;
      logic [2:0]     col;
      logic [2:0]     row;
      int             i;
      col = it.pad_index[2:0];
      row = it.pad_index[5:3];
      case (it.action)
         ACT_STRIP: begin
            if (it.pressed) strip_held = 1'b1;
            else drop_strip();
         end
         ACT_PAGE: drop_strip();
         ACT_PAD: begin
            if (strip_held && row == 3'(STRIP_ROW)) strip_pad_event(col, it.pressed);
            else if (it.pressed) step_val[col] = TOP_ROW_INV - row;
         end
         ACT_TICK: begin
            if (it.reset_tick) begin
               play_col = loop_first;
               div_cnt  = '0;
            end
            if (it.clock_tick) begin
               div_cnt = div_cnt + DIV_W'(1);
               if (div_cnt >= cfg_divide) begin
                  div_cnt = '0;
                  if (play_col < loop_first || play_col >= loop_last) play_col = loop_first;
                  else play_col = play_col + 3'(1);
                  pulse_cnt = cfg_trig;
               end
            end
            main_lvl = slew_level(main_lvl, aim_level(step_val[play_col]));
            for (i = 0; i < STEPS; i++)
               col_lvl[i] = slew_level(col_lvl[i], aim_level(step_val[i]));
            trig = (pulse_cnt != 0);
            if (trig) pulse_cnt = pulse_cnt - 16'd1;
            for (i = 0; i <= STEPS; i++) begin
               r.channel      = CHANNEL_W'(i);
               r.level        = (i == 0) ? main_lvl : col_lvl[i-1];
               r.trigger_high = trig;
               r.playhead     = play_col;
               r.last         = (i == STEPS);
               if (i == 0 && pin.on) begin
                  r.level        = pin.level;
                  r.trigger_high = pin.trigger_high;
                  r.playhead     = pin.playhead;
               end
               expected_levels.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                         input logic [31:0] act_v, input int chan);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t: %s mismatch on channel %0d: expected %0d, actual %0d",
                  $time, name, chan, exp_v, act_v);
      end
   endfunction

   function automatic void check_level(input level_item_type got);
      level_item_type want;
      int             chan;
      if (expected_levels.size() == 0) begin
         mismatches++;
         $display("%0t: result item with none expected: expected nothing, %s %0d level %0d",
                  $time, "actual channel", got.channel, got.level);
         return;
      end
      want = expected_levels.pop_front();
      chan = int'(want.channel);
      results_checked++;
      compare_field("channel", 32'(want.channel), 32'(got.channel), chan);
      compare_field("level", 32'(want.level), 32'(got.level), chan);
      compare_field("trigger_high", 32'(want.trigger_high), 32'(got.trigger_high), chan);
      compare_field("playhead", 32'(want.playhead), 32'(got.playhead), chan);
      compare_field("last", 32'(want.last), 32'(got.last), chan);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_sequencer();
         expected_levels.delete();
         quiet_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_level({rsp_ch.channel, rsp_ch.level, rsp_ch.trigger_high,
                         rsp_ch.playhead, rsp_ch.last});
         if (csr_ch.valid && csr_ch.ready) write_setting(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            run_item({req_ch.action, req_ch.clock_tick, req_ch.reset_tick,
                      req_ch.pad_index, req_ch.pressed}, cur_pin);
            if (req_ch.action == ACT_TICK) ticks_accepted++;
            else others_accepted++;
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (csr_ch.valid && csr_ch.ready) ||
             (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      pending = expected_levels.size();
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= full_speed || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending);
      $display("FAILURE");
      $finish;
   end

   function automatic seq_item_type make_item(input action_type act, input logic clk,
                                              input logic rst, input logic [PAD_W-1:0] pad,
                                              input logic down);
      seq_item_type it;
      it.action     = act;
      it.clock_tick = clk;
      it.reset_tick = rst;
      it.pad_index  = pad;
      it.pressed    = down;
      return it;
   endfunction

   function automatic logic [PAD_W-1:0] pad_at(input int row, input int col);
      return PAD_W'(row * 8 + col);
   endfunction

   function automatic main_pin_type pin_main(input level_type lvl, input logic trg,
                                             input logic [PLAY_W-1:0] ph);
      main_pin_type p;
      p.on           = 1'b1;
      p.level        = lvl;
      p.trigger_high = trg;
      p.playhead     = ph;
      return p;
   endfunction

   function automatic seq_item_type random_tick();
      return make_item(ACT_TICK, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 5,
                       PAD_W'($urandom), 1'($urandom_range(0, 1)));
   endfunction

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_item(input seq_item_type it, input main_pin_type pin = '0);
      while (!full_speed && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      cur_pin = pin;
      req_ch.valid      <= 1'b1;
      req_ch.action     <= it.action;
      req_ch.clock_tick <= it.clock_tick;
      req_ch.reset_tick <= it.reset_tick;
      req_ch.pad_index  <= it.pad_index;
      req_ch.pressed    <= it.pressed;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_setting(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic random_burst(input int tick_pct);
      int roll;
      int pick;
      int a;
      int b;
      roll = $urandom_range(0, 99);
      a = $urandom_range(0, STEPS - 1);
      b = $urandom_range(0, STEPS - 1);
      if (roll < tick_pct) begin
         send_item(random_tick());
      end else if (roll < tick_pct + (100 - tick_pct) / 3) begin
         send_item(make_item(ACT_PAD, 1'b0, 1'b0, PAD_W'($urandom),
                             1'($urandom_range(0, 1))));
      end else if (roll < tick_pct + (100 - tick_pct) / 3 + 5) begin
         send_item(make_item(action_type'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), PAD_W'($urandom),
                             1'($urandom_range(0, 1))));
      end else begin
         // strip gesture: tap, pair, abandoned press or a value edit while held
         send_item(make_item(ACT_STRIP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             PAD_W'($urandom), 1'b1));
         pick = $urandom_range(0, 4);
         case (pick)
            0: begin
               send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b1));
               if ($urandom_range(0, 1)) send_item(random_tick());
               send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b0));
            end
            1, 2: begin
               send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b1));
               send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, b), 1'b1));
               if ($urandom_range(0, 1)) send_item(random_tick());
               if (pick == 1) begin
                  send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b0));
                  send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, b), 1'b0));
               end else begin
                  send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, b), 1'b0));
                  send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b0));
               end
            end
            3: send_item(make_item(ACT_PAD, 1'b0, 1'b0, pad_at(STRIP_ROW, a), 1'b1));
            default:
               send_item(make_item(ACT_PAD, 1'b0, 1'b0,
                                   pad_at($urandom_range(0, STRIP_ROW - 1), a), 1'b1));
         endcase
         if ($urandom_range(0, 1)) send_item(random_tick());
         roll = $urandom_range(0, 9);
         if (roll < 6)
            send_item(make_item(ACT_STRIP, 1'b0, 1'b0, PAD_W'($urandom), 1'b0));
         else if (roll < 8)
            send_item(make_item(ACT_PAGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                PAD_W'($urandom), 1'($urandom_range(0, 1))));
      end
   endtask

   function automatic phase_type make_phase(input logic [CSR_DAT_W-1:0] divide,
                                            input logic [CSR_DAT_W-1:0] slew,
                                            input logic [CSR_DAT_W-1:0] trig,
                                            input int items, input int tick_pct,
                                            input bit fast, input bit press, input bit spare);
      phase_type p;
      p.divide      = divide;
      p.slew        = slew;
      p.trig        = trig;
      p.items       = items;
      p.tick_pct    = tick_pct;
      p.full_speed  = fast;
      p.pressure    = press;
      p.spare_write = spare;
      return p;
   endfunction

   function automatic dir_row_type dir_row(input seq_item_type it, input main_pin_type pin);
      dir_row_type r;
      r.it  = it;
      r.pin = pin;
      return r;
   endfunction

   initial begin
      dir_row_type rows[$];
      phase_type   phases[$];
      int          phase_end;
      int          i;
      bit          hold_done;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = ACT_TICK;
      req_ch.clock_tick = 1'b0;
      req_ch.reset_tick = 1'b0;
      req_ch.pad_index  = '0;
      req_ch.pressed    = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_CLOCK_DIVIDE;
      csr_ch.data       = '0;
      cur_pin           = '0;
      full_speed        = 1'b0;
      hold_rsp          = 1'b0;
      hold_done         = 1'b0;
      mismatches        = 0;
      results_checked   = 0;
      ticks_accepted    = 0;
      others_accepted   = 0;
      items_sent        = 0;
      pending           = 0;
      quiet_cycles      = 0;

      // settings after reset: divide 1, slew off, pulse 240
      rows.push_back(dir_row(make_item(ACT_TICK, 0, 0, '0, 0), pin_main(16'd0, 0, 0)));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(0, 0), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 7), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(1, 1), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(2, 2), 0), '0));
      rows.push_back(dir_row(make_item(ACT_TICK, 0, 0, '1, 1), pin_main(16'd65535, 0, 0)));
      rows.push_back(dir_row(make_item(ACT_TICK, 1, 0, '0, 0), pin_main(16'd56173, 1, 1)));
      rows.push_back(dir_row(make_item(ACT_TICK, 1, 1, '0, 0), pin_main(16'd56173, 1, 1)));
      rows.push_back(dir_row(make_item(ACT_STRIP, 0, 0, '0, 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 2), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 2), 0), '0));
      rows.push_back(dir_row(make_item(ACT_TICK, 0, 0, '0, 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 3), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 5), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 3), 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 5), 0), '0));
      rows.push_back(dir_row(make_item(ACT_TICK, 1, 0, '0, 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 7), 1), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 7), 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 4), 1), '0));
      rows.push_back(dir_row(make_item(ACT_STRIP, 0, 0, '0, 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAGE, 0, 0, '0, 0), '0));
      rows.push_back(dir_row(make_item(ACT_TICK, 0, 1, '0, 0), '0));
      rows.push_back(dir_row(make_item(ACT_PAD, 0, 0, pad_at(7, 0), 1), '0));
      rows.push_back(dir_row(make_item(ACT_TICK, 1, 0, '0, 0), '0));

      // divide 0 and 127 (upper data bits set) and the slew and pulse extremes
      phases.push_back(make_phase(16'd3, 16'd1000, 16'd5, 80, 55, 1, 0, 0));
      phases.push_back(make_phase(16'd0, 16'd65535, 16'd1, 60, 55, 0, 1, 0));
      phases.push_back(make_phase(16'd1, 16'd1, 16'd65535, 50, 60, 0, 0, 1));
      phases.push_back(make_phase(16'd64, 16'd20000, 16'd300, 100, 90, 0, 0, 0));
      phases.push_back(make_phase(16'hFF7F, 16'd65534, 16'd2, 20, 80, 0, 0, 0));
      phases.push_back(make_phase(16'd2, 16'd0, 16'd3, 40, 55, 0, 0, 1));

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[r]) send_item(rows[r].it, rows[r].pin);

      foreach (phases[p]) begin
         drain();
         repeat (SETTLE_CYCLES) @(negedge clock);
         if (phases[p].spare_write) send_setting(CSR_SPARE, CSR_DAT_W'($urandom));
         send_setting(CSR_CLOCK_DIVIDE, phases[p].divide);
         send_setting(CSR_SLEW_STEP, phases[p].slew);
         send_setting(CSR_TRIGGER_TICKS, phases[p].trig);
         csr_ch.valid <= 1'b0;
         full_speed = phases[p].full_speed;
         phase_end = items_sent + phases[p].items;
         while (items_sent < phase_end) begin
            if (phases[p].pressure && !hold_done && items_sent + 40 >= phase_end) begin
               // receiver stalls while ticks keep coming, then the sender drains
               hold_done = 1'b1;
               hold_rsp  = 1'b1;
               for (i = 0; i < 12; i++) send_item(random_tick());
               drain();
            end
            random_burst(phases[p].tick_pct);
         end
      end

      drain();
      repeat (END_CYCLES) @(negedge clock);
      $display("Run covered %0d sample ticks and %0d strip, pad and page items;",
               ticks_accepted, others_accepted);
      $display("%0d levels checked with divide 0..127, slew 0..65535, pulse 1..65535; %0d %s",
               results_checked, mismatches, "mismatches.");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
